[hw/rtl/gbsh_pkg.sv]
package gbsh_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_GRID_DEF   = 16;
   localparam int NUM_IMAGES_DEF = 16;

   // Field widths
   localparam int KIND_W   = 2;
   localparam int IMGIDX_W = 4;
   localparam int COORD_W  = 24;
   localparam int FRAC_W   = 8;
   localparam int EXT_W    = 16;
   localparam int VAL_W    = 32;
   localparam int CELL_W   = 8;
   localparam int CNT_W    = 32;
   localparam int SUM_W    = 48;
   localparam int GRID_W   = 5;

   localparam int REQ_DATA_W = 160;
   localparam int RSP_DATA_W = 200;

   // Half a pixel in Q16.8
   localparam int HALF_PIX = 1 << (FRAC_W - 1);
   // Entries of the image index fold table
   localparam int IMG_TBL  = 1 << IMGIDX_W;

   // Request kinds; any other code reads a cell
   localparam logic [KIND_W-1:0] REQ_COUNT = 2'd0;
   localparam logic [KIND_W-1:0] REQ_STATS = 2'd1;

   typedef struct packed {
      logic [1:0]              pad;
      logic [CELL_W-1:0]       read_cell;
      logic signed [VAL_W-1:0] resid_value;
      logic [VAL_W-1:0]        chi2_value;
      logic                    inc_accepted;
      logic                    inc_loaded;
      logic [EXT_W-1:0]        image_height;
      logic [EXT_W-1:0]        image_width;
      logic [COORD_W-1:0]      pos_y;
      logic [COORD_W-1:0]      pos_x;
      logic [IMGIDX_W-1:0]     image_index;
   } req_data_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] resid_total;
      logic [SUM_W-1:0]        chi2_total;
      logic [CNT_W-1:0]        sample_total;
      logic [CNT_W-1:0]        accepted_total;
      logic [CNT_W-1:0]        loaded_total;
      logic [CELL_W-1:0]       cell_index;
   } rsp_data_type;

   // One histogram cell as stored in memory
   typedef struct packed {
      logic signed [SUM_W-1:0] resid;
      logic [SUM_W-1:0]        chi2;
      logic [CNT_W-1:0]        sample;
      logic [CNT_W-1:0]        accepted;
      logic [CNT_W-1:0]        loaded;
   } cell_word_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BIN,
      ST_READ,
      ST_WRITE
   } state_type;

   // Increment, sticking at all ones
   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (v == '1) ? v : v + CNT_W'(1);
   endfunction

endpackage

[hw/rtl/gbsh_div.sv]
module gbsh_div #(
   parameter int SIZE_W = 5
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [gbsh_pkg::EXT_W+SIZE_W-1:0]    dividend_x,
   input  logic [gbsh_pkg::EXT_W+SIZE_W-1:0]    dividend_y,
   input  logic [gbsh_pkg::EXT_W-1:0]           divisor_x,
   input  logic [gbsh_pkg::EXT_W-1:0]           divisor_y,
   input  logic [SIZE_W-1:0]                    size,
   output logic                                 done,
   output logic [SIZE_W-1:0]                    col,
   output logic [SIZE_W-1:0]                    row
);
   import gbsh_pkg::*;

   localparam int DIV_W  = EXT_W + SIZE_W;
   localparam int STEP_W = $clog2(SIZE_W + 1);

   logic [DIV_W-1:0]  dvd [2];
   logic [EXT_W-1:0]  dsr [2];
   logic [DIV_W-1:0]  rem_ff [2];
   logic [DIV_W-1:0]  dsh_ff [2];
   logic [SIZE_W-1:0] quo_ff [2];
   logic              ovf_ff [2];
   logic [SIZE_W-1:0] bin_q [2];
   logic              busy_ff;
   logic [STEP_W-1:0] step_ff;

   assign dvd[0] = dividend_x;
   assign dvd[1] = dividend_y;
   assign dsr[0] = divisor_x;
   assign dsr[1] = divisor_y;

   assign done = busy_ff && (step_ff == STEP_W'(SIZE_W));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
      end else if (busy_ff) begin
         if (done) begin
            busy_ff <= 1'b0;
         end else begin
            step_ff <= step_ff + STEP_W'(1);
         end
      end
   end

   // One restoring quotient bit per lane and cycle
   always_ff @(posedge clock) begin
      for (int i = 0; i < 2; i++) begin
         if (start) begin
            rem_ff[i] <= dvd[i];
            dsh_ff[i] <= {dsr[i], SIZE_W'(0)} >> 1;
            ovf_ff[i] <= dvd[i] >= {dsr[i], SIZE_W'(0)};
            quo_ff[i] <= '0;
         end else if (busy_ff && !done) begin
            if (rem_ff[i] >= dsh_ff[i]) begin
               rem_ff[i] <= rem_ff[i] - dsh_ff[i];
               quo_ff[i] <= (quo_ff[i] << 1) | SIZE_W'(1);
            end else begin
               quo_ff[i] <= quo_ff[i] << 1;
            end
            dsh_ff[i] <= dsh_ff[i] >> 1;
         end
      end
   end

   // Clamp to the last cell of the axis
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         bin_q[i] = (ovf_ff[i] || (quo_ff[i] >= size)) ? size - SIZE_W'(1) : quo_ff[i];
      end
   end

   assign col = bin_q[0];
   assign row = bin_q[1];

endmodule

[hw/rtl/gbsh_ram.sv]
module gbsh_ram #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12,
   parameter int DATA_W = 192
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[hw/rtl/grid_binned_sample_histogram_core.sv]
// Count and stats beats: the request is binned, then the cell is read, updated and written
// back as the result is loaded; SIZE_W = clog2(MAX_GRID + 1) (5 at the default). The
// divider yields one quotient bit per cycle for column and row together. Read beats skip
// binning: memory read, then result load, with no cell write. Requests are taken only when idle.
// Reset: grid size goes to 1, then a clearing pass zeroes the cell memory, one entry per
// cycle, NUM_IMAGES * MAX_GRID * MAX_GRID entries (4096 at defaults); no requests taken.
module grid_binned_sample_histogram_core #(
   parameter int MAX_GRID   = gbsh_pkg::MAX_GRID_DEF,
   parameter int NUM_IMAGES = gbsh_pkg::NUM_IMAGES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // req_type
   input  logic [gbsh_pkg::KIND_W-1:0]       req_tuser,
   // image_index, pos_x, pos_y, image_width, image_height, inc_loaded,
   // inc_accepted, chi2_value, resid_value, read_cell, zero pad
   input  logic [gbsh_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // cell_index, loaded_total, accepted_total, sample_total, chi2_total, resid_total
   output logic [gbsh_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_we,
   input  logic [gbsh_pkg::GRID_W-1:0]       csr_wdata
);
   import gbsh_pkg::*;

   localparam int SIZE_W = $clog2(MAX_GRID + 1);
   localparam int DIV_W  = EXT_W + SIZE_W;
   localparam int MUL_W  = COORD_W + SIZE_W;
   localparam int SQ_W   = 2 * SIZE_W;
   localparam int CELLS  = MAX_GRID * MAX_GRID;
   localparam int DEPTH  = NUM_IMAGES * CELLS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int AX_W   = ADDR_W + 1;
   localparam int IMG_W  = (NUM_IMAGES > 1) ? $clog2(NUM_IMAGES) : 1;
   localparam int SUMX_W = SUM_W + 1;
   localparam int WORD_W = $bits(cell_word_type);

   // ---------------------------------------------------------------------------------------
   // Control and configuration state
   // ---------------------------------------------------------------------------------------
   state_type           state_ff, state_in;
   logic [GRID_W-1:0]   grid_ff;
   logic [ADDR_W-1:0]   clr_addr_ff;
   logic                rsp_valid_ff;

   // Request held while it is binned and the cell is updated
   logic [KIND_W-1:0]   kind_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic [ADDR_W-1:0]   base_ff;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [CELL_W-1:0]   cell_ff, cell_in;
   logic                zero_ff;
   logic                cnt_loaded_ff;
   logic                cnt_acc_ff;
   logic [VAL_W-1:0]    chi2_ff;
   logic signed [VAL_W-1:0] resid_ff;
   rsp_data_type        rsp_data_ff, rsp_data_in;

   req_data_type        req;
   logic                req_fire;
   logic                is_update;
   logic                out_free;
   logic                clr_last;

   // FSM outputs
   logic                div_start;
   logic                rsp_load;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_wr_addr;
   cell_word_type       mem_wr_word;

   // Binning
   logic [SIZE_W-1:0]   size_eff;
   logic [MUL_W-1:0]    prod_x, prod_y;
   logic [DIV_W-1:0]    scaled_x, scaled_y;
   logic [EXT_W-1:0]    ext_x, ext_y;
   logic                div_done;
   logic [SIZE_W-1:0]   bin_col, bin_row;
   logic [SQ_W-1:0]     slot_sq;
   logic [IMG_W-1:0]    img_map [IMG_TBL];
   logic [IMG_W-1:0]    img_cur;
   logic [ADDR_W-1:0]   base_cur;

   // Memory and update
   logic [WORD_W-1:0]   mem_rd_data;
   cell_word_type       rd_word, upd_word;
   logic [SUMX_W-1:0]   chi2_sum;
   logic signed [SUMX_W-1:0] resid_sum;

   assign req       = req_data_type'(req_tdata);
   assign req_fire  = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign clr_last  = clr_addr_ff == ADDR_W'(DEPTH - 1);
   assign is_update = kind_ff inside {REQ_COUNT, REQ_STATS};

   // ---------------------------------------------------------------------------------------
   // Grid size register; out-of-range sizes fold into 1..MAX_GRID
   // ---------------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff <= GRID_W'(1);
      end else if (csr_we) begin
         grid_ff <= csr_wdata;
      end
   end

   always_comb begin
      if (grid_ff == '0) begin
         size_eff = SIZE_W'(1);
      end else if (int'(grid_ff) > MAX_GRID) begin
         size_eff = SIZE_W'(MAX_GRID);
      end else begin
         size_eff = SIZE_W'(grid_ff);
      end
   end

   // ---------------------------------------------------------------------------------------
   // Request front end: fold the image index, scale coordinates by the grid size
   // ---------------------------------------------------------------------------------------
   for (genvar i = 0; i < IMG_TBL; i++) begin : g_img
      assign img_map[i] = IMG_W'(i % NUM_IMAGES);
   end

   assign img_cur  = img_map[req.image_index];
   assign base_cur = ADDR_W'(AX_W'(img_cur) * AX_W'(CELLS));

   always_comb begin
      prod_x   = MUL_W'(req.pos_x - COORD_W'(HALF_PIX)) * MUL_W'(size_eff);
      prod_y   = MUL_W'(req.pos_y - COORD_W'(HALF_PIX)) * MUL_W'(size_eff);
      // Samples left of the first pixel center land in the first column or row
      scaled_x = (req.pos_x < COORD_W'(HALF_PIX)) ? '0 : prod_x[MUL_W-1:FRAC_W];
      scaled_y = (req.pos_y < COORD_W'(HALF_PIX)) ? '0 : prod_y[MUL_W-1:FRAC_W];
      ext_x    = (req.image_width == '0) ? EXT_W'(1) : req.image_width;
      ext_y    = (req.image_height == '0) ? EXT_W'(1) : req.image_height;
   end

   gbsh_div #(
      .SIZE_W (SIZE_W)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .dividend_x (scaled_x),
      .dividend_y (scaled_y),
      .divisor_x  (ext_x),
      .divisor_y  (ext_y),
      .size       (size_ff),
      .done       (div_done),
      .col        (bin_col),
      .row        (bin_row)
   );

   // Cell slot from the binned column and row, with the current stride
   assign slot_sq = SQ_W'(bin_row) * SQ_W'(size_ff) + SQ_W'(bin_col);

   // ---------------------------------------------------------------------------------------
   // Address and cell number: read beats take them at accept, the others when binned
   // ---------------------------------------------------------------------------------------
   always_comb begin
      addr_in = addr_ff;
      cell_in = cell_ff;
      if (req_fire) begin
         addr_in = ADDR_W'(AX_W'(base_cur) + AX_W'(req.read_cell));
         cell_in = req.read_cell;
      end else if (state_ff == ST_BIN) begin
         addr_in = ADDR_W'(AX_W'(base_ff) + AX_W'(slot_sq));
         cell_in = CELL_W'(slot_sq);
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      cell_ff <= cell_in;
      if (req_fire) begin
         kind_ff       <= req_tuser;
         size_ff       <= size_eff;
         base_ff       <= base_cur;
         zero_ff       <= !(req_tuser inside {REQ_COUNT, REQ_STATS})
                          && (int'(req.read_cell) >= CELLS);
         cnt_loaded_ff <= req.inc_loaded;
         cnt_acc_ff    <= req.inc_accepted;
         chi2_ff       <= req.chi2_value;
         resid_ff      <= req.resid_value;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Sequencer: clear, idle, bin, read, write back
   // ---------------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (req_tuser inside {REQ_COUNT, REQ_STATS}) ? ST_BIN : ST_READ;
            end
         end
         ST_BIN: begin
            if (div_done) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            // Hold until the result register is free; read data stays put meanwhile
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      div_start   = 1'b0;
      rsp_load    = 1'b0;
      mem_we      = 1'b0;
      mem_wr_addr = addr_ff;
      mem_wr_word = upd_word;
      case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_wr_addr = clr_addr_ff;
            mem_wr_word = '0;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            div_start  = req_tvalid && (req_tuser inside {REQ_COUNT, REQ_STATS});
         end
         ST_WRITE: begin
            rsp_load = out_free;
            mem_we   = out_free && is_update;
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------------------------------
   // Cell memory and read-modify-write
   // ---------------------------------------------------------------------------------------
   gbsh_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (WORD_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_word),
      .rd_addr (addr_ff),
      .rd_data (mem_rd_data)
   );

   assign rd_word = cell_word_type'(mem_rd_data);

   always_comb begin
      upd_word  = rd_word;
      chi2_sum  = {1'b0, rd_word.chi2} + SUMX_W'(chi2_ff);
      resid_sum = SUMX_W'(rd_word.resid) + SUMX_W'(resid_ff);
      case (kind_ff)
         REQ_COUNT: begin
            if (cnt_loaded_ff) begin
               upd_word.loaded = sat_inc(rd_word.loaded);
            end
            if (cnt_acc_ff) begin
               upd_word.accepted = sat_inc(rd_word.accepted);
            end
         end
         REQ_STATS: begin
            upd_word.sample = sat_inc(rd_word.sample);
            upd_word.chi2   = chi2_sum[SUM_W] ? '1 : chi2_sum[SUM_W-1:0];
            // Clamp the residual sum when the top two bits disagree
            if (resid_sum[SUM_W] != resid_sum[SUM_W-1]) begin
               upd_word.resid = resid_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                 : {1'b0, {(SUM_W-1){1'b1}}};
            end else begin
               upd_word.resid = resid_sum[SUM_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------------------------------
   // Result register: parts the response side from the request side
   // ---------------------------------------------------------------------------------------
   always_comb begin
      rsp_data_in.cell_index = cell_ff;
      if (zero_ff) begin
         rsp_data_in.loaded_total   = '0;
         rsp_data_in.accepted_total = '0;
         rsp_data_in.sample_total   = '0;
         rsp_data_in.chi2_total     = '0;
         rsp_data_in.resid_total    = '0;
      end else begin
         rsp_data_in.loaded_total   = upd_word.loaded;
         rsp_data_in.accepted_total = upd_word.accepted;
         rsp_data_in.sample_total   = upd_word.sample;
         rsp_data_in.chi2_total     = upd_word.chi2;
         rsp_data_in.resid_total    = upd_word.resid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[hw/rtl/gbsh_check.sv]
module gbsh_check (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [gbsh_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled result beat holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // Reset drops the result and starts the clearing pass
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("block not quiet after reset");

   // One request at a time: no request taken right after another
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while the previous one is in flight");

   // A result needs at least the memory read cycle after its request
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result appeared too early");

endmodule

bind grid_binned_sample_histogram_core gbsh_check u_check (.*);
